### rtl/c3nc_pkg.sv
// Shared types, constants and helper functions for the 3x3 normalized convolution block.
`timescale 1ns / 1ps

package c3nc_pkg;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 48;
    localparam int DIM_W     = 12;
    localparam int POS_W     = 22;
    localparam int SIZE_W    = 24;
    localparam int ACC_W     = 32;
    localparam int DSUM_W    = 20;
    localparam int BASE_W    = 16;
    localparam int TAP_CNT_W = 4;
    localparam int NUM_TAPS  = 9;
    localparam int IDX_W     = 3;

    localparam logic [PIX_W-1:0] PIX_CEIL  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_FLOOR = 8'd8;

    localparam logic [IDX_W-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_MIDDLE = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH       = 3'd3;
    localparam logic [IDX_W-1:0] REG_HEIGHT      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic mac_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic mac_last;
        logic div_last;
        logic out_free;
    } dp_sts_t;

    typedef struct packed {
        logic [CFG_W-1:0] coef_top;
        logic [CFG_W-1:0] coef_middle;
        logic [CFG_W-1:0] coef_bottom;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    // Row distance (2 - r) of a window tap, tap = r*3 + s.
    function automatic logic [1:0] tap_row_dist(input logic [TAP_CNT_W-1:0] tap);
        logic [1:0] d;
        unique case (tap)
            4'd0, 4'd1, 4'd2: d = 2'd2;
            4'd3, 4'd4, 4'd5: d = 2'd1;
            default:          d = 2'd0;
        endcase
        return d;
    endfunction

    // Column distance (2 - s) of a window tap.
    function automatic logic [1:0] tap_col_dist(input logic [TAP_CNT_W-1:0] tap);
        logic [1:0] d;
        unique case (tap)
            4'd0, 4'd3, 4'd6: d = 2'd2;
            4'd1, 4'd4, 4'd7: d = 2'd1;
            default:          d = 2'd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [COEF_W-1:0] tap_coef(
        input logic [TAP_CNT_W-1:0] tap,
        input logic [CFG_W-1:0]     top,
        input logic [CFG_W-1:0]     mid,
        input logic [CFG_W-1:0]     bot
    );
        logic [CFG_W-1:0] row;
        logic [1:0]       col;
        logic [COEF_W-1:0] f;
        unique case (tap_row_dist(tap))
            2'd2:    row = top;
            2'd1:    row = mid;
            default: row = bot;
        endcase
        col = 2'd2 - tap_col_dist(tap);
        unique case (col)
            2'd0:    f = row[15:0];
            2'd1:    f = row[31:16];
            default: f = row[47:32];
        endcase
        return $signed(f);
    endfunction

endpackage

### rtl/c3nc_ctrl.sv
// Sequencer for the 3x3 convolution: accept, multiply-accumulate, divide, deliver.
`timescale 1ns / 1ps

module c3nc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output c3nc_pkg::dp_cmd_t cmd,
    input  c3nc_pkg::dp_sts_t sts
);
    import c3nc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && sts.emit)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (sts.mac_last)
                begin
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/c3nc_datapath.sv
// Line store, pixel counter, multiply-accumulate, restoring divider and output register.
`timescale 1ns / 1ps

module c3nc_datapath #(
    parameter int MAX_WIDTH      = 2048,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [c3nc_pkg::PIX_W-1:0]    pixel_in,
    input  logic                          frame_start,
    input  c3nc_pkg::cfg_t                cfg,
    input  c3nc_pkg::dp_cmd_t             cmd,
    output c3nc_pkg::dp_sts_t             sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [c3nc_pkg::PIX_W-1:0]    pixel_out,
    output logic [c3nc_pkg::POS_W-1:0]    out_position,
    output logic                          frame_last,
    output logic                          filter_rejected
);
    import c3nc_pkg::*;

    localparam int HIST_LEN = 2 * MAX_WIDTH + 3;
    localparam int AW       = $clog2(HIST_LEN);
    localparam int QW       = BASE_W + COEF_FRAC_BITS;

    // pixel history ring
    logic [PIX_W-1:0] line_store [HIST_LEN];
    logic [AW-1:0]    hist_wr_reg;
    logic [AW-1:0]    item_wr_reg;
    logic [PIX_W-1:0] rd_data_reg;

    logic [POS_W-1:0] pixel_counter_reg;
    logic [POS_W-1:0] pos_reg;
    logic             last_reg;

    logic [TAP_CNT_W-1:0]    tap_cnt_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DSUM_W-1:0] dsum_reg;

    logic [QW-1:0]     num_reg;
    logic [DSUM_W-1:0] rem_reg;
    logic [5:0]        div_cnt_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic             out_last_reg;
    logic             out_rej_reg;

    // item bookkeeping at accept
    logic [POS_W-1:0]  p;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] p_ext;
    logic [SIZE_W-1:0] p_inc;
    logic [SIZE_W-1:0] lead;
    logic              emit;
    logic [AW-1:0]     hist_wr_inc;

    assign p     = frame_start ? '0 : pixel_counter_reg;
    assign size  = SIZE_W'(cfg.width) * SIZE_W'(cfg.height);
    assign p_ext = SIZE_W'(p);
    assign p_inc = p_ext + SIZE_W'(1);
    assign lead  = (SIZE_W'(cfg.width) << 1) + SIZE_W'(2);
    assign emit  = (p_ext >= lead) && (p_ext < size);
    assign hist_wr_inc = (hist_wr_reg == AW'(HIST_LEN - 1)) ? '0 : hist_wr_reg + AW'(1);

    // read address of the current tap
    logic [AW:0]   age;
    logic [AW:0]   rd_base;
    logic [AW-1:0] rd_addr;
    logic [1:0]    rdist;

    assign rdist = tap_row_dist(tap_cnt_reg);

    always_comb
    begin
        unique case (rdist)
            2'd2:    age = (AW+1)'(cfg.width) << 1;
            2'd1:    age = (AW+1)'(cfg.width);
            default: age = '0;
        endcase
        age = age + (AW+1)'(tap_col_dist(tap_cnt_reg));
        if ((AW+1)'(item_wr_reg) >= age)
        begin
            rd_base = (AW+1)'(item_wr_reg);
        end
        else
        begin
            rd_base = (AW+1)'(item_wr_reg) + (AW+1)'(HIST_LEN);
        end
        rd_addr = AW'(rd_base - age);
    end

    // multiply-accumulate of the tap whose pixel was read last cycle
    logic signed [COEF_W-1:0] coef_cur;
    logic signed [COEF_W+PIX_W:0] prod;

    assign coef_cur = tap_coef(tap_cnt_reg - TAP_CNT_W'(1),
                               cfg.coef_top, cfg.coef_middle, cfg.coef_bottom);
    assign prod     = coef_cur * $signed({1'b0, rd_data_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            line_store[hist_wr_reg] <= pixel_in;
        end
        if (cmd.mac_step && (tap_cnt_reg < TAP_CNT_W'(NUM_TAPS)))
        begin
            rd_data_reg <= line_store[rd_addr];
        end
    end

    // saturated, truncated base and divider step
    logic signed [ACC_W-1:0] acc_sh;
    logic [BASE_W-1:0]       base;
    logic [DSUM_W-1:0]       rem_sh;
    logic                    qbit;

    always_comb
    begin
        acc_sh = acc_reg >>> COEF_FRAC_BITS;
        if (acc_reg <= 0)
        begin
            base = '0;
        end
        else if (acc_sh > ACC_W'(65535))
        begin
            base = '1;
        end
        else
        begin
            base = acc_sh[BASE_W-1:0];
        end
        rem_sh = {rem_reg[DSUM_W-2:0], num_reg[QW-1]};
        qbit   = (rem_sh >= $unsigned(dsum_reg));
    end

    // final result selection
    logic [PIX_W-1:0] result;

    always_comb
    begin
        priority if (dsum_reg == '0)
        begin
            result = '0;
        end
        else if (dsum_reg < 0)
        begin
            result = PIX_FLOOR;
        end
        else if (num_reg > QW'(PIX_CEIL))
        begin
            result = PIX_CEIL;
        end
        else if (num_reg < QW'(PIX_FLOOR))
        begin
            result = PIX_FLOOR;
        end
        else
        begin
            result = num_reg[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_wr_reg       <= '0;
            pixel_counter_reg <= '0;
            tap_cnt_reg       <= '0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                hist_wr_reg       <= hist_wr_inc;
                pixel_counter_reg <= (p_inc >= size) ? '0 : p_inc[POS_W-1:0];
                tap_cnt_reg       <= '0;
            end
            else if (cmd.mac_step)
            begin
                tap_cnt_reg <= tap_cnt_reg + TAP_CNT_W'(1);
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= 6'(QW);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_wr_reg <= hist_wr_reg;
            pos_reg     <= p - POS_W'(cfg.width) - POS_W'(1);
            last_reg    <= (p_ext == size - SIZE_W'(1));
            acc_reg     <= '0;
            dsum_reg    <= '0;
        end
        else if (cmd.mac_step && (tap_cnt_reg != '0))
        begin
            acc_reg  <= acc_reg + ACC_W'(prod);
            dsum_reg <= dsum_reg + DSUM_W'(coef_cur);
        end
        if (cmd.div_load)
        begin
            num_reg <= {base, {COEF_FRAC_BITS{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[QW-2:0], qbit};
            rem_reg <= qbit ? rem_sh - $unsigned(dsum_reg) : rem_sh;
        end
        if (cmd.out_load)
        begin
            out_pix_reg  <= result;
            out_pos_reg  <= pos_reg;
            out_last_reg <= last_reg;
            out_rej_reg  <= (dsum_reg == '0);
        end
    end

    assign sts.emit     = emit;
    assign sts.mac_last = (tap_cnt_reg == TAP_CNT_W'(NUM_TAPS));
    assign sts.div_last = (div_cnt_reg == 6'd1);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign pixel_out       = out_pix_reg;
    assign out_position    = out_pos_reg;
    assign frame_last      = out_last_reg;
    assign filter_rejected = out_rej_reg;

endmodule

### rtl/conv3x3_normalized_clamp_top.sv
// Top level of the streaming 3x3 normalized convolution with output clamp.
`timescale 1ns / 1ps

// 3x3 normalized convolution over an 8-bit raster pixel stream. Each accepted
// item is one pixel; neighbors are taken by linear index, so edge columns wrap
// into the adjacent rows. The weighted sum (signed Q-format coefficients,
// COEF_FRAC_BITS fraction bits) is truncated, saturated to 0..65535, divided by
// the coefficient sum and clamped to 8..255; a zero coefficient sum gives 0
// with the rejection flag (tuser) set. Results for centers W+1 .. W*H-W-2 are
// produced, each when pixel center+W+1 arrives; tlast marks the last one.
// Sequence: a pixel that produces no result needs only its accept step. A pixel
// with a result holds off the next pixel until its steps are done, plus any wait
// for the output register: an accept step, the reads of the nine window pixels
// through the single read port of the line store, each multiply-accumulated in
// the cycle after its read, a divider load, 16 + COEF_FRAC_BITS restoring
// divider steps (one quotient bit per cycle) and a load into the output
// register. The line store holds 2*MAX_WIDTH+3 pixels and needs no clearing.
// Configuration: write only while idle; sizes are saturated into 3..MAX.

module conv3x3_normalized_clamp_top #(
    parameter int MAX_WIDTH      = 2048,
    parameter int MAX_HEIGHT     = 2048,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tuser,   // [0] frame_start
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] pixel_out, [29:8] out_position, rest zero
    output logic        m_axis_tuser,   // [0] filter_rejected
    output logic        m_axis_tlast,   // frame_last
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);
    import c3nc_pkg::*;

    cfg_t cfg_reg;

    // size register writes saturate into the legal range
    logic [DIM_W-1:0] wr_dim;
    logic [DIM_W-1:0] width_sat;
    logic [DIM_W-1:0] height_sat;

    assign wr_dim = cfg_wdata[DIM_W-1:0];

    always_comb
    begin
        priority if (wr_dim < DIM_W'(3))
        begin
            width_sat = DIM_W'(3);
        end
        else if (32'(wr_dim) > MAX_WIDTH)
        begin
            width_sat = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            width_sat = wr_dim;
        end
        priority if (wr_dim < DIM_W'(3))
        begin
            height_sat = DIM_W'(3);
        end
        else if (32'(wr_dim) > MAX_HEIGHT)
        begin
            height_sat = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            height_sat = wr_dim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_top    <= '0;
            cfg_reg.coef_middle <= 48'h0000_0100_0000;  // 1.0 at the center tap
            cfg_reg.coef_bottom <= '0;
            cfg_reg.width       <= DIM_W'(1280);
            cfg_reg.height      <= DIM_W'(1024);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COEF_TOP)
            begin
                cfg_reg.coef_top <= cfg_wdata;
            end
            if (cfg_index == REG_COEF_MIDDLE)
            begin
                cfg_reg.coef_middle <= cfg_wdata;
            end
            if (cfg_index == REG_COEF_BOTTOM)
            begin
                cfg_reg.coef_bottom <= cfg_wdata;
            end
            if (cfg_index == REG_WIDTH)
            begin
                cfg_reg.width <= width_sat;
            end
            if (cfg_index == REG_HEIGHT)
            begin
                cfg_reg.height <= height_sat;
            end
        end
    end

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] out_position;

    c3nc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    c3nc_datapath #(
        .MAX_WIDTH      (MAX_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_in        (s_axis_tdata),
        .frame_start     (s_axis_tuser),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .pixel_out       (pixel_out),
        .out_position    (out_position),
        .frame_last      (m_axis_tlast),
        .filter_rejected (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, out_position, pixel_out};

endmodule
